FILE: rtl/mtiem_pkg.sv
package mtiem_pkg;

    // number of buttons, knobs and stored led bits
    localparam int ENTRIES = 8;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // depth of the command queue between front and back
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // upper nibble of a status byte
    localparam logic [3:0] MSG_NOTE_OFF   = 4'h8;
    localparam logic [3:0] MSG_NOTE_ON    = 4'h9;
    localparam logic [3:0] MSG_CTRL       = 4'hB;
    localparam logic [3:0] MSG_PROGRAM    = 4'hC;
    localparam logic [3:0] MSG_CHAN_PRESS = 4'hD;
    localparam logic [3:0] MSG_SYSTEM     = 4'hF;

    localparam logic [7:0] ECHO_STATUS_ON  = 8'h90;
    localparam logic [7:0] ECHO_STATUS_OFF = 8'h80;
    localparam logic [6:0] ECHO_VELOCITY   = 7'h7F;

    localparam logic [3:0] CHANNEL_RST     = 4'd0;
    localparam logic [6:0] BUTTON_BASE_RST = 7'h24;
    localparam logic [6:0] KNOB_BASE_RST   = 7'd1;

    typedef enum logic [1:0] {
        KIND_BUTTON = 2'd0,
        KIND_KNOB   = 2'd1,
        KIND_SYNC   = 2'd2,
        KIND_ECHO   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_DATA1 = 2'd1,
        PH_DATA2 = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        REG_MIDI_CHANNEL = 2'd0,
        REG_BUTTON_BASE  = 2'd1,
        REG_KNOB_BASE    = 2'd2,
        REG_LED_FB_EN    = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        STEP_EVENT = 2'd0,
        STEP_ECHO  = 2'd1,
        STEP_SYNC  = 2'd2
    } step_t;

    typedef struct packed {
        logic [3:0] channel;
        logic [6:0] button_base;
        logic [6:0] knob_base;
        logic       led_fb_en;
    } cfg_t;

    // one queued command: up to three results
    typedef struct packed {
        logic             ev_valid;
        logic             ev_knob;
        logic [2:0]       slot;
        logic [7:0]       level;
        logic             echo_valid;
        logic [IDX_W-1:0] echo_idx;
        logic [6:0]       echo_note;
        logic             led_wr;
        logic             led_val;
        logic             sync;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [2:0] slot_of(input logic [IDX_W-1:0] idx);
        logic [7:0] wide;
        wide = 8'(idx);
        return wide[2:0];
    endfunction

endpackage

FILE: rtl/mtiem_front.sv
module mtiem_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  mtiem_pkg::cfg_t    cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               req_type,
    input  logic [7:0]         midi_byte,
    input  logic [7:0]         led_number,
    input  logic               led_on,
    input  mtiem_pkg::q_stat_t q_stat,
    output logic               push,
    output mtiem_pkg::cmd_t    cmd
);
    import mtiem_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] held_status_reg, held_status_next;
    logic [7:0] first_data_reg, first_data_next;
    logic       accept;
    logic       finish;
    logic [7:0] d1, d2;
    logic [3:0] msg_type;
    logic       on_chan;
    logic [8:0] btn_diff, knob_diff;
    logic       btn_hit, knob_hit;
    logic [IDX_W-1:0] btn_idx, knob_idx, led_idx;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;
    assign msg_type = held_status_reg[7:4];
    assign on_chan  = (held_status_reg[3:0] == cfg.channel);

    // key and controller range checks, borrow in the top bit
    assign btn_diff  = {1'b0, d1} - {2'b00, cfg.button_base};
    assign knob_diff = {1'b0, d1} - {2'b00, cfg.knob_base};
    assign btn_hit   = !btn_diff[8] && (btn_diff[7:0] < 8'(ENTRIES));
    assign knob_hit  = !knob_diff[8] && (knob_diff[7:0] < 8'(ENTRIES));
    assign btn_idx   = btn_diff[IDX_W-1:0];
    assign knob_idx  = knob_diff[IDX_W-1:0];
    assign led_idx   = led_number[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
        end else begin
            phase_reg <= phase_next;
        end
        held_status_reg <= held_status_next;
        first_data_reg  <= first_data_next;
    end

    // parser
    always_comb begin
        phase_next       = phase_reg;
        held_status_next = held_status_reg;
        first_data_next  = first_data_reg;
        finish           = 1'b0;
        d1               = first_data_reg;
        d2               = midi_byte;
        if (accept && !req_type) begin
            unique case (phase_reg)
                PH_HUNT: begin
                    if (midi_byte[7] && (midi_byte[7:4] != MSG_SYSTEM)) begin
                        held_status_next = midi_byte;
                        phase_next       = PH_DATA1;
                    end
                end
                PH_DATA1: begin
                    if (msg_type == MSG_PROGRAM || msg_type == MSG_CHAN_PRESS) begin
                        phase_next = PH_HUNT;
                        finish     = 1'b1;
                        d1         = midi_byte;
                        d2         = 8'h00;
                    end else begin
                        first_data_next = midi_byte;
                        phase_next      = PH_DATA2;
                    end
                end
                PH_DATA2: begin
                    phase_next = PH_HUNT;
                    finish     = 1'b1;
                end
                default: begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    // classify into a command for the back end
    always_comb begin
        cmd  = '0;
        push = 1'b0;
        if (accept && req_type) begin
            if (cfg.led_fb_en && (led_number < 8'(ENTRIES))) begin
                push           = 1'b1;
                cmd.echo_valid = 1'b1;
                cmd.echo_idx   = led_idx;
                cmd.echo_note  = cfg.button_base + 7'(led_idx);
                cmd.led_wr     = 1'b1;
                cmd.led_val    = led_on;
            end
        end else if (finish) begin
            push     = 1'b1;
            cmd.sync = 1'b1;
            if (on_chan && (msg_type == MSG_NOTE_OFF || msg_type == MSG_NOTE_ON)) begin
                if (btn_hit) begin
                    cmd.ev_valid = 1'b1;
                    cmd.slot     = slot_of(btn_idx);
                    cmd.level    = {7'd0, (msg_type == MSG_NOTE_ON) && (d2 != 8'h00)};
                    if (cfg.led_fb_en) begin
                        cmd.echo_valid = 1'b1;
                        cmd.echo_idx   = btn_idx;
                        cmd.echo_note  = cfg.button_base + 7'(btn_idx);
                    end
                end
            end else if (on_chan && msg_type == MSG_CTRL) begin
                if (knob_hit) begin
                    cmd.ev_valid = 1'b1;
                    cmd.ev_knob  = 1'b1;
                    cmd.slot     = slot_of(knob_idx);
                    cmd.level    = d2;
                end
            end
        end
    end

endmodule

FILE: rtl/mtiem_queue.sv
module mtiem_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  mtiem_pkg::cmd_t    push_cmd,
    input  logic               pop,
    output mtiem_pkg::cmd_t    head_cmd,
    output mtiem_pkg::q_stat_t q_stat
);
    import mtiem_pkg::*;

    cmd_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign q_stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign head_cmd     = entry_reg[rd_ptr_reg];
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: rtl/mtiem_back.sv
module mtiem_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  mtiem_pkg::cmd_t    head_cmd,
    input  mtiem_pkg::q_stat_t q_stat,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output mtiem_pkg::kind_t   out_kind,
    output logic [2:0]         out_slot,
    output logic [7:0]         out_level,
    output logic [7:0]         out_echo_status,
    output logic [6:0]         out_echo_note,
    output logic [6:0]         out_echo_velocity,
    output logic               out_last
);
    import mtiem_pkg::*;

    step_t      step_reg, step_next, sel;
    logic       led_bits_reg [ENTRIES];
    logic       valid_reg, valid_next;
    kind_t      kind_reg, kind_next;
    logic [2:0] slot_reg, slot_next;
    logic [7:0] level_reg, level_next;
    logic [7:0] est_reg, est_next;
    logic [6:0] note_reg, note_next;
    logic [6:0] vel_reg, vel_next;
    logic       last_reg, last_next;
    logic       load, last, led_state, led_write;

    assign load      = !q_stat.empty && (!valid_reg || out_ready);
    assign led_state = head_cmd.led_wr ? head_cmd.led_val : led_bits_reg[head_cmd.echo_idx];
    assign led_write = load && (sel == STEP_ECHO) && head_cmd.led_wr;

    // pick the next pending result of the head command
    always_comb begin
        if (head_cmd.ev_valid && step_reg == STEP_EVENT) begin
            sel  = STEP_EVENT;
            last = !(head_cmd.echo_valid || head_cmd.sync);
        end else if (head_cmd.echo_valid && step_reg != STEP_SYNC) begin
            sel  = STEP_ECHO;
            last = !head_cmd.sync;
        end else begin
            sel  = STEP_SYNC;
            last = 1'b1;
        end
    end

    always_comb begin
        step_next  = step_reg;
        valid_next = valid_reg;
        kind_next  = kind_reg;
        slot_next  = slot_reg;
        level_next = level_reg;
        est_next   = est_reg;
        note_next  = note_reg;
        vel_next   = vel_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        if (out_ready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
            last_next  = last;
            slot_next  = '0;
            level_next = '0;
            est_next   = '0;
            note_next  = '0;
            vel_next   = '0;
            unique case (sel)
                STEP_EVENT: begin
                    kind_next  = head_cmd.ev_knob ? KIND_KNOB : KIND_BUTTON;
                    slot_next  = head_cmd.slot;
                    level_next = head_cmd.level;
                    step_next  = STEP_ECHO;
                end
                STEP_ECHO: begin
                    kind_next = KIND_ECHO;
                    est_next  = led_state ? ECHO_STATUS_ON : ECHO_STATUS_OFF;
                    note_next = head_cmd.echo_note;
                    vel_next  = ECHO_VELOCITY;
                    step_next = STEP_SYNC;
                end
                default: begin
                    kind_next = KIND_SYNC;
                end
            endcase
            if (last) begin
                pop       = 1'b1;
                step_next = STEP_EVENT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= STEP_EVENT;
            valid_reg <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                led_bits_reg[i] <= 1'b0;
            end
        end else begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
            if (led_write) begin
                led_bits_reg[head_cmd.echo_idx] <= head_cmd.led_val;
            end
        end
        kind_reg  <= kind_next;
        slot_reg  <= slot_next;
        level_reg <= level_next;
        est_reg   <= est_next;
        note_reg  <= note_next;
        vel_reg   <= vel_next;
        last_reg  <= last_next;
    end

    assign out_valid         = valid_reg;
    assign out_kind          = kind_reg;
    assign out_slot          = slot_reg;
    assign out_level         = level_reg;
    assign out_echo_status   = est_reg;
    assign out_echo_note     = note_reg;
    assign out_echo_velocity = vel_reg;
    assign out_last          = last_reg;

endmodule

FILE: rtl/midi_to_input_event_mapper_top.sv
// midi channel message parser that maps notes and controllers onto button and knob
// events. each input transaction is a midi byte (s_tuser = 0) or a host led change
// (s_tuser = 1). a front end parses status and data bytes and turns every completed
// channel message, and each led change with feedback on and an index in range, into
// a command; a two-entry queue carries commands to a back end that emits one result
// transaction per cycle while the receiver is ready: button or knob event, led echo,
// sync report, with m_tlast on the last result of each input. an input transaction
// is taken every cycle while the queue has room; an input with several results (at
// most three) keeps the back end busy until its last result loads, so one input per
// cycle is sustained only for single-result traffic. configuration must be written
// through cfg_we / cfg_index / cfg_wdata while the block is idle (not enforced).
module midi_to_input_event_mapper_top (
    input  logic        aclk,
    input  logic        aresetn,

    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // midi_byte[7:0], led_number[15:8], led_on[16], zero pad
    input  logic        s_tuser,    // req_type[0]

    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // slot[2:0], level[10:3], echo_status[18:11],
                                    // echo_note[25:19], echo_velocity[32:26], zero pad
    output logic [1:0]  m_tuser,    // kind[1:0]
    output logic        m_tlast,    // final_res

    // configuration writes
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_wdata
);
    import mtiem_pkg::*;

    cfg_t    cfg_reg;
    cmd_t    push_cmd, head_cmd;
    q_stat_t q_stat;
    logic    push, pop;
    kind_t   out_kind;
    logic [2:0] out_slot;
    logic [7:0] out_level, out_est;
    logic [6:0] out_note, out_vel;

    // configuration registers, one per index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.channel     <= CHANNEL_RST;
            cfg_reg.button_base <= BUTTON_BASE_RST;
            cfg_reg.knob_base   <= KNOB_BASE_RST;
            cfg_reg.led_fb_en   <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MIDI_CHANNEL: cfg_reg.channel     <= cfg_wdata[3:0];
                REG_BUTTON_BASE:  cfg_reg.button_base <= cfg_wdata;
                REG_KNOB_BASE:    cfg_reg.knob_base   <= cfg_wdata;
                REG_LED_FB_EN:    cfg_reg.led_fb_en   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // front end: byte parser and message classifier
    mtiem_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .req_type   (s_tuser),
        .midi_byte  (s_tdata[7:0]),
        .led_number (s_tdata[15:8]),
        .led_on     (s_tdata[16]),
        .q_stat     (q_stat),
        .push       (push),
        .cmd        (push_cmd)
    );

    // command queue decouples parsing from result emission
    mtiem_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_stat   (q_stat)
    );

    // back end: result sequencer, led bits and output register
    mtiem_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .head_cmd          (head_cmd),
        .q_stat            (q_stat),
        .pop               (pop),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .out_kind          (out_kind),
        .out_slot          (out_slot),
        .out_level         (out_level),
        .out_echo_status   (out_est),
        .out_echo_note     (out_note),
        .out_echo_velocity (out_vel),
        .out_last          (m_tlast)
    );

    assign m_tuser = out_kind;
    assign m_tdata = {7'd0, out_vel, out_note, out_est, out_level, out_slot};

endmodule

FILE: rtl/mtiem_checker.sv
module mtiem_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);
    import mtiem_pkg::*;

    // stalled result holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    // no result right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // sync report always closes the input's results
    a_sync_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_SYNC |-> m_tlast)
        else $error("sync report not last");

    // button level is 0 or 1
    a_button_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_BUTTON |-> m_tdata[10:4] == 7'd0)
        else $error("button level out of range");

    // echo carries full velocity and a note status
    a_echo: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_ECHO |-> m_tdata[32:26] == ECHO_VELOCITY
            && (m_tdata[18:11] == ECHO_STATUS_ON || m_tdata[18:11] == ECHO_STATUS_OFF))
        else $error("malformed echo");

endmodule

bind midi_to_input_event_mapper_top mtiem_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import mtiem_pkg::*;

    // timing of the run
    localparam int RUN_LIMIT_NS    = 2_000_000;  // far above a correct run
    localparam int DRAIN_CYCLES    = 8;
    localparam int HOLD_CYCLES     = 200;        // long receiver hold-off
    localparam int ITEMS_PER_PHASE = 75;
    localparam int PHASES          = 6;
    localparam int MAX_PRINTS      = 40;

    // channel messages the block has no special handling for
    localparam logic [3:0] MSG_POLY_PRESS = 4'hA;
    localparam logic [3:0] MSG_PITCH_BEND = 4'hE;

    // one result transaction, fields as they come out of the block
    typedef struct packed {
        kind_t      kind;
        logic [2:0] slot;
        logic [7:0] level;
        logic [7:0] est;
        logic [6:0] note;
        logic [6:0] vel;
        logic       last;
    } res_t;

    // one row of stimulus: a register write or an input transaction,
    // optionally with the results typed in by hand
    typedef struct packed {
        logic         is_cfg;
        cfg_reg_t     reg_sel;
        logic [6:0]   cfg_val;
        logic         req;
        logic [7:0]   midi_b;
        logic [7:0]   led_num;
        logic         led_val;
        logic         typed;
        logic [1:0]   n_typed;
        res_t [2:0]   exp_res;
    } row_t;

    // dut signals, every input known from time zero
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [6:0]  cfg_wdata = '0;

    // mapper model state and its copy of the registers
    logic [3:0]         chan_q     = CHANNEL_RST;
    logic [6:0]         btn_base_q = BUTTON_BASE_RST;
    logic [6:0]         knob_base_q = KNOB_BASE_RST;
    logic               fb_en_q    = 1'b0;
    phase_t             phase_q    = PH_HUNT;
    logic [7:0]         held_q     = '0;
    logic [7:0]         first_q    = '0;
    logic [ENTRIES-1:0] led_state  = '0;

    res_t pending_events[$];     // results still owed by the block
    row_t plan[$];               // directed stimulus table
    int   mismatches = 0;
    bit   hold_req   = 1'b0;     // asks the result sink for a long hold-off
    bit   gapless    = 1'b0;     // sender offers back to back
    int   burst_left = 0;

    midi_to_input_event_mapper_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // safety net against a hung block
    initial begin
        #(RUN_LIMIT_NS);
        $display("midi_to_input_event_mapper_top regression: fail");
        $finish;
    end

    // ---------------------------------------------------------------
    // mapper model
    // ---------------------------------------------------------------

    function automatic res_t mk_res(input kind_t k, input logic [2:0] s, input logic [7:0] lv,
                                    input logic [7:0] es, input logic [6:0] nt);
        res_t r;
        r.kind  = k;
        r.slot  = s;
        r.level = lv;
        r.est   = es;
        r.note  = nt;
        r.vel   = (k == KIND_ECHO) ? ECHO_VELOCITY : 7'd0;
        r.last  = 1'b0;
        return r;
    endfunction

    // echo of the stored led bit, note wraps to 7 bits
    function automatic res_t echo_of(input logic [IDX_W-1:0] idx);
        return mk_res(KIND_ECHO, 3'd0, 8'd0,
                      led_state[idx] ? ECHO_STATUS_ON : ECHO_STATUS_OFF,
                      btn_base_q + 7'(idx));
    endfunction

    // a completed channel message: optional event, optional echo, always a sync
    function automatic void close_message(input logic [7:0] d1, input logic [7:0] d2,
                                          output res_t [2:0] out, output int n);
        int   offs;
        logic on_chan;
        n       = 0;
        out     = '0;
        on_chan = (held_q[3:0] == chan_q);
        if (on_chan && (held_q[7:4] == MSG_NOTE_OFF || held_q[7:4] == MSG_NOTE_ON)) begin
            // key compared at 8 bits, so keys above 127 can still hit
            offs = int'(d1) - int'(btn_base_q);
            if (offs >= 0 && offs < ENTRIES) begin
                out[n] = mk_res(KIND_BUTTON, 3'(offs),
                                (held_q[7:4] == MSG_NOTE_ON && d2 != 8'd0) ? 8'd1 : 8'd0,
                                8'd0, 7'd0);
                n++;
                if (fb_en_q) begin
                    out[n] = echo_of(IDX_W'(offs));
                    n++;
                end
            end
        end else if (on_chan && held_q[7:4] == MSG_CTRL) begin
            offs = int'(d1) - int'(knob_base_q);
            if (offs >= 0 && offs < ENTRIES) begin
                out[n] = mk_res(KIND_KNOB, 3'(offs), d2, 8'd0, 7'd0);
                n++;
            end
        end
        out[n] = mk_res(KIND_SYNC, 3'd0, 8'd0, 8'd0, 7'd0);
        n++;
    endfunction

    // results caused by one accepted input transaction
    function automatic void map_item(input row_t r, output res_t [2:0] out, output int n);
        n   = 0;
        out = '0;
        if (r.req) begin
            // led change: ignored unless feedback is on and the index exists
            if (fb_en_q && r.led_num < ENTRIES) begin
                led_state[r.led_num[IDX_W-1:0]] = r.led_val;
                out[0] = echo_of(r.led_num[IDX_W-1:0]);
                n = 1;
            end
        end else begin
            case (phase_q)
                PH_HUNT: begin
                    // data bytes and system bytes are dropped while hunting
                    if (r.midi_b[7] && r.midi_b[7:4] != MSG_SYSTEM) begin
                        held_q  = r.midi_b;
                        phase_q = PH_DATA1;
                    end
                end
                PH_DATA1: begin
                    if (held_q[7:4] == MSG_PROGRAM || held_q[7:4] == MSG_CHAN_PRESS) begin
                        phase_q = PH_HUNT;
                        close_message(r.midi_b, 8'd0, out, n);
                    end else begin
                        first_q = r.midi_b;
                        phase_q = PH_DATA2;
                    end
                end
                default: begin
                    phase_q = PH_HUNT;
                    close_message(first_q, r.midi_b, out, n);
                end
            endcase
        end
        if (n > 0)
            out[n-1].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // stimulus rows
    // ---------------------------------------------------------------

    // midi byte, unused led fields filled with noise
    function automatic row_t mk_byte(input logic [7:0] b);
        row_t r;
        r         = '0;
        r.midi_b  = b;
        r.led_num = 8'($urandom);
        r.led_val = 1'($urandom);
        return r;
    endfunction

    function automatic row_t mk_led(input logic [7:0] num, input logic on);
        row_t r;
        r         = '0;
        r.req     = 1'b1;
        r.midi_b  = 8'($urandom);
        r.led_num = num;
        r.led_val = on;
        return r;
    endfunction

    function automatic row_t mk_cfg(input cfg_reg_t sel, input logic [6:0] val);
        row_t r;
        r         = '0;
        r.is_cfg  = 1'b1;
        r.reg_sel = sel;
        r.cfg_val = val;
        return r;
    endfunction

    // attach a hand-typed result to the newest row of the table
    function automatic void plan_exp(input kind_t k, input logic [2:0] s, input logic [7:0] lv,
                                     input logic [7:0] es, input logic [6:0] nt);
        row_t r;
        r = plan[plan.size()-1];
        r.exp_res[r.n_typed] = mk_res(k, s, lv, es, nt);
        r.typed   = 1'b1;
        r.n_typed = r.n_typed + 2'd1;
        plan[plan.size()-1] = r;
    endfunction

    // newest row must cause nothing
    function automatic void plan_none();
        plan[plan.size()-1].typed = 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------

    // offer one input transaction in the sender's burst pattern,
    // record what it owes once accepted
    task automatic offer_item(input row_t r);
        int         gap;
        res_t [2:0] pred;
        int         n;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(24, 48)
                                                     : $urandom_range(1, 8);
            gap = gapless ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, r.led_val, r.led_num, r.midi_b};
        s_tuser  <= r.req;
        do @(posedge aclk); while (!s_tready);
        map_item(r, pred, n);
        if (r.typed) begin
            pred = r.exp_res;
            n    = r.n_typed;
            if (n > 0)
                pred[n-1].last = 1'b1;
        end
        for (int k = 0; k < n; k++)
            pending_events.push_back(pred[k]);
    endtask

    // stop offering and let every owed result come out
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // single register write, model copy follows at the same edge
    task automatic write_reg(input cfg_reg_t sel, input logic [6:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_wdata <= val;
        @(posedge aclk);
        case (sel)
            REG_MIDI_CHANNEL: chan_q      = val[3:0];
            REG_BUTTON_BASE:  btn_base_q  = val;
            REG_KNOB_BASE:    knob_base_q = val;
            default:          fb_en_q     = val[0];
        endcase
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_config(input logic [3:0] ch, input logic [6:0] bb,
                                input logic [6:0] kb, input logic fb);
        settle();
        write_reg(REG_MIDI_CHANNEL, {3'd0, ch});
        write_reg(REG_BUTTON_BASE, bb);
        write_reg(REG_KNOB_BASE, kb);
        write_reg(REG_LED_FB_EN, {6'd0, fb});
    endtask

    // one random piece of traffic: mostly well-formed messages aimed at the
    // button and knob ranges, some led changes, some noise and cut messages
    task automatic send_random_message(inout int sent);
        int         pick;
        int         nbytes;
        logic [3:0] typ;
        logic [3:0] ch;
        logic [7:0] d1;
        logic [7:0] d2;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            // led change, index mostly in range
            offer_item(mk_led(($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                          : 8'($urandom_range(0, ENTRIES - 1)),
                              1'($urandom)));
            sent++;
        end else if (pick < 22) begin
            // stray byte, not counted toward the phase
            offer_item(mk_byte(8'($urandom)));
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2: typ = MSG_NOTE_ON;
                3, 4:    typ = MSG_NOTE_OFF;
                5, 6:    typ = MSG_CTRL;
                7:       typ = MSG_PROGRAM;
                8:       typ = MSG_CHAN_PRESS;
                default: typ = ($urandom_range(0, 1) == 1) ? MSG_POLY_PRESS : MSG_PITCH_BEND;
            endcase
            ch = ($urandom_range(0, 4) != 0) ? chan_q : 4'($urandom);
            d1 = 8'($urandom);
            if ($urandom_range(0, 3) != 0) begin
                // key or controller inside the mapped window, may pass 127
                if (typ == MSG_NOTE_ON || typ == MSG_NOTE_OFF)
                    d1 = {1'b0, btn_base_q} + 8'($urandom_range(0, ENTRIES - 1));
                else if (typ == MSG_CTRL)
                    d1 = {1'b0, knob_base_q} + 8'($urandom_range(0, ENTRIES - 1));
            end
            d2 = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
            nbytes = (typ == MSG_PROGRAM || typ == MSG_CHAN_PRESS) ? 2 : 3;
            // now and then a message is cut short, the next status lands as data
            if ($urandom_range(0, 19) == 0)
                nbytes--;
            offer_item(mk_byte({typ, ch}));
            sent++;
            if (nbytes > 1) begin
                offer_item(mk_byte(d1));
                sent++;
            end
            if (nbytes > 2) begin
                offer_item(mk_byte(d2));
                sent++;
            end
        end
    endtask

    // ---------------------------------------------------------------
    // result sink: stalls in stretches of its own pattern, plus one
    // long hold-off on request
    // ---------------------------------------------------------------
    initial begin : result_sink
        int mode;
        int span;
        int tick;
        tick = 0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 96);
            repeat (span) begin
                @(posedge aclk);
                tick++;
                if (hold_req) begin
                    hold_req = 1'b0;
                    m_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge aclk);
                end
                case (mode)
                    0:       m_tready <= 1'b1;                          // always ready
                    1:       m_tready <= ($urandom_range(0, 1) == 1);   // coin flip
                    2:       m_tready <= (tick % 4 == 0);               // one cycle in four
                    default: m_tready <= ($urandom_range(0, 7) != 0);   // rare stalls
                endcase
            end
        end
    end

    // ---------------------------------------------------------------
    // result checker: every result transaction against the oldest owed one
    // ---------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("%0t: %s mismatch, got %0h, want %0h", $time, what, got, want);
    endtask

    always @(posedge aclk) begin : result_check
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_events.size() == 0) begin
                report_mismatch("unowed result kind", m_tuser, 0);
            end else begin
                want = pending_events.pop_front();
                if (m_tuser != want.kind)
                    report_mismatch("kind", m_tuser, want.kind);
                if (m_tdata[2:0] != want.slot)
                    report_mismatch("slot", m_tdata[2:0], want.slot);
                if (m_tdata[10:3] != want.level)
                    report_mismatch("level", m_tdata[10:3], want.level);
                if (m_tdata[18:11] != want.est)
                    report_mismatch("echo status", m_tdata[18:11], want.est);
                if (m_tdata[25:19] != want.note)
                    report_mismatch("echo note", m_tdata[25:19], want.note);
                if (m_tdata[32:26] != want.vel)
                    report_mismatch("echo velocity", m_tdata[32:26], want.vel);
                if (m_tlast != want.last)
                    report_mismatch("last flag", m_tlast, want.last);
            end
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin : main_flow
        int  sent;
        bit  pressed;
        pressed = 1'b0;

        // directed table, registers at reset values: channel 0, buttons at
        // note 36, knobs from controller 1, no led feedback
        plan.push_back(mk_byte(8'h45));                      // data while hunting
        plan_none();
        plan.push_back(mk_byte(8'hFF));                      // system byte dropped
        plan_none();
        plan.push_back(mk_byte(8'h90));                      // note on, first button, full velocity
        plan.push_back(mk_byte(8'h24));
        plan.push_back(mk_byte(8'h7F));
        plan_exp(KIND_BUTTON, 3'd0, 8'd1, 8'd0, 7'd0);
        plan_exp(KIND_SYNC, 3'd0, 8'd0, 8'd0, 7'd0);
        plan.push_back(mk_byte(8'h80));                      // note off, last button,
        plan.push_back(mk_byte(8'h2B));                      // status byte taken as velocity
        plan.push_back(mk_byte(8'hF8));
        plan_exp(KIND_BUTTON, 3'd7, 8'd0, 8'd0, 7'd0);
        plan_exp(KIND_SYNC, 3'd0, 8'd0, 8'd0, 7'd0);
        plan.push_back(mk_byte(8'h90));                      // note on with zero velocity
        plan.push_back(mk_byte(8'h25));
        plan.push_back(mk_byte(8'h00));
        plan_exp(KIND_BUTTON, 3'd1, 8'd0, 8'd0, 7'd0);
        plan_exp(KIND_SYNC, 3'd0, 8'd0, 8'd0, 7'd0);
        plan.push_back(mk_byte(8'hB0));                      // first knob, raw value 0xff
        plan.push_back(mk_byte(8'h01));
        plan.push_back(mk_byte(8'hFF));
        plan_exp(KIND_KNOB, 3'd0, 8'hFF, 8'd0, 7'd0);
        plan_exp(KIND_SYNC, 3'd0, 8'd0, 8'd0, 7'd0);
        plan.push_back(mk_byte(8'hCF));                      // program change, other channel
        plan.push_back(mk_byte(8'h00));
        plan_exp(KIND_SYNC, 3'd0, 8'd0, 8'd0, 7'd0);
        plan.push_back(mk_byte(8'hD0));                      // channel pressure, status as data
        plan.push_back(mk_byte(8'h80));
        plan_exp(KIND_SYNC, 3'd0, 8'd0, 8'd0, 7'd0);
        plan.push_back(mk_byte(8'hEF));                      // pitch bend, only a sync
        plan.push_back(mk_byte(8'h7F));
        plan.push_back(mk_byte(8'h7F));
        plan_exp(KIND_SYNC, 3'd0, 8'd0, 8'd0, 7'd0);
        plan.push_back(mk_led(8'd0, 1'b1));                  // led change with feedback off
        plan_none();
        plan.push_back(mk_cfg(REG_LED_FB_EN, 7'd1));
        plan.push_back(mk_led(8'd3, 1'b1));                  // led change echoed
        plan_exp(KIND_ECHO, 3'd0, 8'd0, ECHO_STATUS_ON, 7'd39);
        plan.push_back(mk_byte(8'h90));                      // three results: event, echo, sync
        plan.push_back(mk_byte(8'h27));
        plan.push_back(mk_byte(8'h01));
        plan_exp(KIND_BUTTON, 3'd3, 8'd1, 8'd0, 7'd0);
        plan_exp(KIND_ECHO, 3'd0, 8'd0, ECHO_STATUS_ON, 7'd39);
        plan_exp(KIND_SYNC, 3'd0, 8'd0, 8'd0, 7'd0);
        plan.push_back(mk_led(8'hFF, 1'b1));                 // led index out of range
        plan_none();

        // hold reset at the start, then never again
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                settle();
                write_reg(plan[i].reg_sel, plan[i].cfg_val);
            end else begin
                offer_item(plan[i]);
            end
        end

        // random phases, each under its own register setting; phase
        // boundaries drain every owed result but not the parser state, so
        // registers may change in the middle of a parsed message
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       apply_config(4'd15, 7'd0, 7'd0, 1'b1);
                1:       apply_config(4'($urandom), 7'd127, 7'd127, 1'b1);
                2:       apply_config(4'd0, 7'd120, 7'd124, 1'b0);
                default: apply_config(4'($urandom), 7'($urandom), 7'($urandom),
                                      1'($urandom));
            endcase
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                // back-pressure: receiver holds off while the sender keeps offering
                if (ph == 1 && sent >= 10 && !pressed) begin
                    pressed  = 1'b1;
                    gapless  = 1'b1;
                    hold_req = 1'b1;
                end
                if (ph == 1 && sent >= 60)
                    gapless = 1'b0;
                send_random_message(sent);
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("midi_to_input_event_mapper_top regression: pass");
        end else begin
            $display("midi_to_input_event_mapper_top regression: fail");
        end
        $finish;
    end

endmodule
